>>> design/rpa_pkg.sv
// Shared types and constants for the reference-counted page allocator.
package rpa_pkg;

  localparam int PAGES_DEF    = 32768;
  localparam int REF_BITS_DEF = 8;

  localparam int OP_W       = 3;
  localparam int PAGE_NUM_W = 15;
  localparam int STATUS_W   = 2;
  localparam int REF_OUT_W  = 8;
  localparam int COUNT_W    = 16;

  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_INC   = 3'd3;
  localparam logic [OP_W-1:0] OP_DEC   = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [PAGE_NUM_W-1:0] page_number;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PAGE_NUM_W-1:0] granted_page;
    logic [REF_OUT_W-1:0]  ref_count;
    logic [COUNT_W-1:0]    free_count;
  } out_word_t;

endpackage

>>> design/rpa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/refcounted_page_allocator.sv
// Page allocator: LIFO free-page stack plus per-page reference counts.
// Each word: memory read (registered RAM read port), then modify/write-back in S_EXEC,
// which registers the result; no new word is taken meanwhile; out_stall holds S_EXEC.
// Init sweeps the usable range one page a cycle, first_usable_page to the last page.
// Reset clears control, stack depth and first_usable_page; RAM contents are not cleared,
// counts are valid only after an init.
module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int PAGES    = PAGES_DEF,
  parameter int REF_BITS = REF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [PAGE_NUM_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  localparam int PAGE_W  = $clog2(PAGES);
  localparam int DEPTH_W = $clog2(PAGES + 1);
  localparam int RW      = (REF_BITS > REF_OUT_W) ? REF_BITS : REF_OUT_W;

  localparam logic [DEPTH_W-1:0]    PAGES_D   = DEPTH_W'(PAGES);
  localparam logic [PAGE_NUM_W:0]   PAGES_N   = (PAGE_NUM_W + 1)'(PAGES);
  localparam logic [PAGE_W-1:0]     LAST_PAGE = PAGE_W'(PAGES - 1);
  localparam logic [REF_BITS-1:0]   REF_MAX   = '1;
  localparam logic [REF_BITS-1:0]   REF_ONE   = REF_BITS'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INIT
  } state_t;

  state_t                state;
  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    depth_next;
  logic [DEPTH_W-1:0]    depth_m1;
  logic [PAGE_NUM_W-1:0] first_usable;
  logic [OP_W-1:0]       op_q;
  logic [PAGE_NUM_W-1:0] page_q;
  logic [PAGE_W-1:0]     init_page;

  logic                  in_accept;
  logic                  exec_go;
  logic                  in_rng;
  logic [REF_BITS-1:0]   ref_q;
  logic [PAGE_NUM_W-1:0] stk_q;
  logic [REF_BITS-1:0]   cnt;
  logic [RW-1:0]         cnt_x;
  out_word_t             res;

  logic                  ex_ref_we;
  logic [PAGE_W-1:0]     ex_ref_waddr;
  logic [REF_BITS-1:0]   ex_ref_wdata;
  logic                  ex_stk_we;

  logic                  ref_we;
  logic [PAGE_W-1:0]     ref_waddr;
  logic [REF_BITS-1:0]   ref_wdata;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_waddr;
  logic [PAGE_NUM_W-1:0] stk_wdata;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign exec_go   = (state == S_EXEC) && !(out_valid && out_stall);
  assign depth_m1  = depth - DEPTH_W'(1);
  assign in_rng    = (page_q >= first_usable) && ({1'b0, page_q} < PAGES_N);

  rpa_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (PAGES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (in_accept),
    .raddr (in_word.page_number[PAGE_W-1:0]),
    .rdata (ref_q)
  );

  rpa_ram #(
    .WIDTH (PAGE_NUM_W),
    .DEPTH (PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (in_accept),
    .raddr (depth_m1[PAGE_W-1:0]),
    .rdata (stk_q)
  );

  always_comb begin
    res          = '0;
    depth_next   = depth;
    cnt          = '0;
    ex_ref_we    = 1'b0;
    ex_ref_waddr = page_q[PAGE_W-1:0];
    ex_ref_wdata = '0;
    ex_stk_we    = 1'b0;
    case (op_q)
      OP_INIT: begin
      end
      OP_ALLOC: begin
        if (depth == '0) begin
          res.status = ST_NOMEM;
        end else begin
          depth_next       = depth_m1;
          res.granted_page = stk_q;
          ex_ref_we        = 1'b1;
          ex_ref_waddr     = stk_q[PAGE_W-1:0];
          ex_ref_wdata     = REF_ONE;
          cnt              = REF_ONE;
        end
      end
      OP_FREE: begin
        if (!in_rng) begin
          res.status = ST_RANGE;
        end else if (ref_q != '0) begin
          ex_ref_we    = 1'b1;
          ex_ref_wdata = ref_q - REF_ONE;
          cnt          = ref_q - REF_ONE;
          if (ref_q == REF_ONE && depth < PAGES_D) begin
            ex_stk_we  = 1'b1;
            depth_next = depth + DEPTH_W'(1);
          end
        end
      end
      OP_INC, OP_DEC, OP_QUERY: begin
        if (!in_rng) begin
          res.status = ST_RANGE;
        end else begin
          cnt = ref_q;
          if (op_q == OP_INC && ref_q != REF_MAX) begin
            cnt = ref_q + REF_ONE;
          end else if (op_q == OP_DEC && ref_q != '0) begin
            cnt = ref_q - REF_ONE;
          end
          ex_ref_we    = (cnt != ref_q);
          ex_ref_wdata = cnt;
        end
      end
      default: begin
      end
    endcase
    cnt_x          = RW'(cnt);
    res.ref_count  = cnt_x[REF_OUT_W-1:0];
    res.free_count = COUNT_W'(depth_next);
  end

  always_comb begin
    if (state == S_INIT) begin
      ref_we    = 1'b1;
      ref_waddr = init_page;
      ref_wdata = '0;
      stk_we    = 1'b1;
      stk_wdata = PAGE_NUM_W'(init_page);
    end else begin
      ref_we    = exec_go && ex_ref_we;
      ref_waddr = ex_ref_waddr;
      ref_wdata = ex_ref_wdata;
      stk_we    = exec_go && ex_stk_we;
      stk_wdata = page_q;
    end
    stk_waddr = depth[PAGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      depth        <= '0;
      first_usable <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        first_usable <= cfg_data;
      end
      out_valid <= out_valid && out_stall;
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op_q   <= in_word.op;
            page_q <= in_word.page_number;
            state  <= S_EXEC;
            if (in_word.op == OP_INIT) begin
              depth <= '0;
              if ({1'b0, first_usable} < PAGES_N) begin
                init_page <= first_usable[PAGE_W-1:0];
                state     <= S_INIT;
              end
            end
          end
        end
        S_INIT: begin
          depth     <= depth + DEPTH_W'(1);
          init_page <= init_page + PAGE_W'(1);
          if (init_page == LAST_PAGE) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            depth     <= depth_next;
            out_word  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
